// File: rtl/ppcm_pkg.sv
// ----------------------------------------------------------------------------
// ppcm_pkg
// Shared constants, register codes and the arctangent table of the polar
// panorama coordinate map.
// ----------------------------------------------------------------------------
package ppcm_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF     = 5;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int COORD_BITS_DEF    = 12;

   // angle unit is pi / 2^ANG_SHIFT, vectors get VEC_GUARD guard bits
   localparam int ANG_SHIFT = 28;
   localparam int VEC_GUARD = 16;

   // configuration register widths and reset values
   localparam int W_BITS     = 13;
   localparam int H_BITS     = 12;
   localparam int W_RESET    = 1024;
   localparam int H_RESET    = 512;

   // result field widths and saturation limits
   localparam int SRC_X_BITS = 17;
   localparam int SRC_Y_BITS = 16;
   localparam int SRC_X_MAX  = 131071;
   localparam int SRC_Y_MAX  = 65535;

   // configuration port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BIT   = 2;

   typedef enum logic {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } csr_reg_type;

   // round(atan(2^-i) * 2^28 / pi)
   function automatic logic [ANG_SHIFT-1:0] atan_entry(input logic [4:0] idx);
      logic [ANG_SHIFT-1:0] val;
      case (idx)
         5'd0:    val = 28'd67108864;
         5'd1:    val = 28'd39616676;
         5'd2:    val = 28'd20932363;
         5'd3:    val = 28'd10625595;
         5'd4:    val = 28'd5333416;
         5'd5:    val = 28'd2669308;
         5'd6:    val = 28'd1334980;
         5'd7:    val = 28'd667531;
         5'd8:    val = 28'd333770;
         5'd9:    val = 28'd166886;
         5'd10:   val = 28'd83443;
         5'd11:   val = 28'd41722;
         5'd12:   val = 28'd20861;
         5'd13:   val = 28'd10430;
         5'd14:   val = 28'd5215;
         5'd15:   val = 28'd2608;
         5'd16:   val = 28'd1304;
         5'd17:   val = 28'd652;
         5'd18:   val = 28'd326;
         5'd19:   val = 28'd163;
         5'd20:   val = 28'd81;
         5'd21:   val = 28'd41;
         5'd22:   val = 28'd20;
         5'd23:   val = 28'd10;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/polar_panorama_coord_map_unit.sv
// ----------------------------------------------------------------------------
// polar_panorama_coord_map_unit
// Maps an output pixel of a disk image to its sample position in a W by H
// source strip: angle by a pipelined CORDIC, radius by a pipelined square root.
// ----------------------------------------------------------------------------
// While rsp_stall is low, one request enters per cycle and one response leaves
// per cycle. K, the larger of CORDIC_STAGES and the square root's bit count
// COORD_BITS + 1 + FRAC_BITS (with COORD_BITS taken as at least 12), sets the
// number of iteration stages. Each CORDIC iteration and each square root bit
// owns one register stage, and both run side by side in the same stages. Stages
// with no valid item fill up under a response stall, so requests are still
// taken until the pipeline is full. src_width and src_height are read while
// items are in flight: change them only when the pipeline is empty.
module polar_panorama_coord_map_unit #(
   parameter int FRAC_BITS     = ppcm_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = ppcm_pkg::CORDIC_STAGES_DEF,
   parameter int COORD_BITS    = ppcm_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [COORD_BITS-1:0]                req_out_x,
   input  logic [COORD_BITS-1:0]                req_out_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_inside_res,
   output logic [ppcm_pkg::SRC_X_BITS-1:0]      rsp_src_x,
   output logic [ppcm_pkg::SRC_Y_BITS-1:0]      rsp_src_y,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ppcm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ppcm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ppcm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import ppcm_pkg::*;

   localparam int CW   = (COORD_BITS > H_BITS) ? COORD_BITS : H_BITS;
   localparam int DW   = CW + 1;
   localparam int SQW  = 2 * CW;
   localparam int D2W  = 2 * CW + 1;
   localparam int R2W  = 2 * H_BITS;
   localparam int VW   = CW + VEC_GUARD + 3;
   localparam int ZW   = ANG_SHIFT + 2;
   localparam int THW  = ANG_SHIFT + 1;
   localparam int RB   = CW + 1 + FRAC_BITS;
   localparam int NR   = 2 * RB + 1;
   localparam int K    = (CORDIC_STAGES > RB) ? CORDIC_STAGES : RB;
   localparam int YW   = (RB + 1 > SRC_Y_BITS) ? RB + 1 : SRC_Y_BITS;
   localparam int PW   = W_BITS + THW;
   localparam int SXW  = PW + FRAC_BITS + 1;
   localparam int ST_A = 0;
   localparam int ST_C = 2;
   localparam int ST_D = K + 3;
   localparam int ST_E = K + 4;
   localparam int ST_O = K + 5;
   localparam int NS   = K + 6;

   // ---------------------------------------------------------------- registers
   logic [W_BITS-1:0] src_width_ff;
   logic [H_BITS-1:0] src_height_ff;
   logic              csr_wr;
   logic [H_BITS-1:0] radius;
   logic [W_BITS-1:0] wscale;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= W_BITS'(W_RESET);
         src_height_ff <= H_BITS'(H_RESET);
      end else if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[CSR_IDX_BIT]))
            REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[W_BITS-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[H_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[CSR_IDX_BIT]))
         REG_SRC_WIDTH:  csr_prdata = CSR_DATA_BITS'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = CSR_DATA_BITS'(src_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign radius = (src_height_ff != '0) ? src_height_ff - H_BITS'(1) : '0;
   assign wscale = (src_width_ff != '0) ? src_width_ff - W_BITS'(1) : '0;

   // ---------------------------------------------------------------- flow control
   // a stage moves when it is empty or the stage after it moves
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] valid_up;
   logic [NS:0]   adv;

   assign adv[NS]  = ~rsp_stall;
   assign valid_up = {valid_ff[NS-2:0], req_valid};

   for (genvar s = 0; s < NS; s++) begin : g_adv
      assign adv[s]      = ~valid_ff[s] | adv[s+1];
      assign valid_in[s] = adv[s] ? valid_up[s] : valid_ff[s];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~adv[ST_A];
   assign rsp_valid = valid_ff[ST_O];

   // ---------------------------------------------------------------- stage A: offsets
   logic signed [DW-1:0] dx_a_ff, dx_a_in;
   logic signed [DW-1:0] dy_raw;
   logic        [DW-1:0] dy_mag;
   logic        [CW-1:0] dy_a_ff, dy_a_in;

   always_comb begin
      dx_a_in = $signed(DW'(req_out_x)) - $signed(DW'(src_height_ff));
      dy_raw  = $signed(DW'(req_out_y)) - $signed(DW'(src_height_ff));
      dy_mag  = dy_raw[DW-1] ? DW'(-dy_raw) : DW'(dy_raw);
      dy_a_in = dy_mag[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_A]) begin
         dx_a_ff <= dx_a_in;
         dy_a_ff <= dy_a_in;
      end
   end

   // ---------------------------------------------------------------- stage B: squares
   logic [DW-1:0]  dx_mag;
   logic [CW-1:0]  adx_b_ff, adx_b_in;
   logic [CW-1:0]  dy_b_ff;
   logic           neg_b_ff;
   logic [SQW-1:0] sqx_b_ff, sqx_b_in;
   logic [SQW-1:0] sqy_b_ff, sqy_b_in;
   logic [R2W-1:0] rad2_b_ff, rad2_b_in;

   always_comb begin
      dx_mag    = dx_a_ff[DW-1] ? DW'(-dx_a_ff) : DW'(dx_a_ff);
      adx_b_in  = dx_mag[CW-1:0];
      sqx_b_in  = SQW'(adx_b_in) * SQW'(adx_b_in);
      sqy_b_in  = SQW'(dy_a_ff) * SQW'(dy_a_ff);
      rad2_b_in = R2W'(radius) * R2W'(radius);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_A+1]) begin
         adx_b_ff  <= adx_b_in;
         dy_b_ff   <= dy_a_ff;
         neg_b_ff  <= dx_a_ff[DW-1];
         sqx_b_ff  <= sqx_b_in;
         sqy_b_ff  <= sqy_b_in;
         rad2_b_ff <= rad2_b_in;
      end
   end

   // ---------------------------------------------------------------- stage C and iterations
   // entry j of these arrays sits in stage ST_C + j
   logic signed [VW-1:0] vx_ff   [0:K];
   logic signed [VW-1:0] vy_ff   [0:K];
   logic signed [ZW-1:0] z_ff    [0:K];
   logic        [NR-1:0] rem_ff  [0:K];
   logic        [RB-1:0] root_ff [0:K];
   logic        [K:0]    neg_ff;
   logic        [K:0]    axh_ff;
   logic        [K:0]    axv_ff;
   logic        [K:0]    ins_ff;

   logic signed [VW-1:0] vx_in   [0:K-1];
   logic signed [VW-1:0] vy_in   [0:K-1];
   logic signed [ZW-1:0] z_in    [0:K-1];
   logic        [NR-1:0] rem_in  [0:K-1];
   logic        [RB-1:0] root_in [0:K-1];

   logic [D2W-1:0] d2_c;

   assign d2_c = D2W'(sqx_b_ff) + D2W'(sqy_b_ff);

   // CORDIC rotation k and square root bit RB-1-k share stage ST_C+1+k
   always_comb begin
      logic signed [VW-1:0] sx;
      logic signed [VW-1:0] sy;
      logic        [NR-1:0] trial;
      for (int k = 0; k < K; k++) begin
         vx_in[k]   = vx_ff[k];
         vy_in[k]   = vy_ff[k];
         z_in[k]    = z_ff[k];
         rem_in[k]  = rem_ff[k];
         root_in[k] = root_ff[k];
         sx         = vx_ff[k] >>> k;
         sy         = vy_ff[k] >>> k;
         trial      = (NR'(root_ff[k]) << (RB - k)) + (NR'(1) << (2 * (RB - 1 - k)));
         if (k < CORDIC_STAGES) begin
            if (!vy_ff[k][VW-1]) begin
               vx_in[k] = vx_ff[k] + sy;
               vy_in[k] = vy_ff[k] - sx;
               z_in[k]  = z_ff[k] + $signed(ZW'(atan_entry(5'(k))));
            end else begin
               vx_in[k] = vx_ff[k] - sy;
               vy_in[k] = vy_ff[k] + sx;
               z_in[k]  = z_ff[k] - $signed(ZW'(atan_entry(5'(k))));
            end
         end
         if (k < RB) begin
            if (rem_ff[k] >= trial) begin
               rem_in[k]  = rem_ff[k] - trial;
               root_in[k] = root_ff[k] | (RB'(1) << (RB - 1 - k));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_C]) begin
         vx_ff[0]   <= $signed(VW'(adx_b_ff) << VEC_GUARD);
         vy_ff[0]   <= $signed(VW'(dy_b_ff) << VEC_GUARD);
         z_ff[0]    <= '0;
         rem_ff[0]  <= NR'(d2_c) << (2 * FRAC_BITS);
         root_ff[0] <= '0;
         neg_ff[0]  <= neg_b_ff;
         axh_ff[0]  <= (dy_b_ff == '0);
         axv_ff[0]  <= (adx_b_ff == '0);
         ins_ff[0]  <= (d2_c < D2W'(rad2_b_ff));
      end
      for (int k = 0; k < K; k++) begin
         if (adv[ST_C+1+k]) begin
            vx_ff[k+1]   <= vx_in[k];
            vy_ff[k+1]   <= vy_in[k];
            z_ff[k+1]    <= z_in[k];
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
            neg_ff[k+1]  <= neg_ff[k];
            axh_ff[k+1]  <= axh_ff[k];
            axv_ff[k+1]  <= axv_ff[k];
            ins_ff[k+1]  <= ins_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- stage D: angle, rounding
   localparam logic [THW-1:0] HALF_PI = THW'(1) << (ANG_SHIFT - 1);
   localparam logic [THW-1:0] FULL_PI = THW'(1) << ANG_SHIFT;

   logic [THW-1:0] zc;
   logic [THW-1:0] theta_d_ff, theta_d_in;
   logic [RB:0]    root_d_ff, root_d_in;
   logic           ins_d_ff;

   always_comb begin
      // clamp the first-quadrant angle to [0, pi/2]
      if (z_ff[K][ZW-1]) begin
         zc = '0;
      end else if (z_ff[K] > $signed(ZW'(HALF_PI))) begin
         zc = HALF_PI;
      end else begin
         zc = z_ff[K][THW-1:0];
      end
      if (axh_ff[K]) begin
         theta_d_in = neg_ff[K] ? FULL_PI : '0;
      end else if (axv_ff[K]) begin
         theta_d_in = HALF_PI;
      end else begin
         theta_d_in = neg_ff[K] ? FULL_PI - zc : zc;
      end
      root_d_in = (RB+1)'(root_ff[K]) + (RB+1)'(rem_ff[K] > NR'(root_ff[K]));
   end

   always_ff @(posedge clock) begin
      if (adv[ST_D]) begin
         theta_d_ff <= theta_d_in;
         root_d_ff  <= root_d_in;
         ins_d_ff   <= ins_ff[K];
      end
   end

   // ---------------------------------------------------------------- stage E: scale, row
   logic [PW-1:0]         prod_e_ff, prod_e_in;
   logic [YW-1:0]         top_y;
   logic [YW-1:0]         sy_full;
   logic [SRC_Y_BITS-1:0] sy_e_ff, sy_e_in;
   logic                  ins_e_ff;

   always_comb begin
      prod_e_in = PW'(wscale) * PW'(theta_d_ff);
      top_y     = YW'(radius) << FRAC_BITS;
      sy_full   = (top_y > YW'(root_d_ff)) ? top_y - YW'(root_d_ff) : '0;
      sy_e_in   = (sy_full > YW'(SRC_Y_MAX)) ? SRC_Y_BITS'(SRC_Y_MAX)
                                             : sy_full[SRC_Y_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_E]) begin
         prod_e_ff <= prod_e_in;
         sy_e_ff   <= sy_e_in;
         ins_e_ff  <= ins_d_ff;
      end
   end

   // ---------------------------------------------------------------- stage O: output
   logic [SXW-1:0]        sx_full;
   logic [SXW-1:0]        sx_shr;
   logic [SRC_X_BITS-1:0] sx_sat;
   logic                  inside_ff;
   logic [SRC_X_BITS-1:0] src_x_ff;
   logic [SRC_Y_BITS-1:0] src_y_ff;

   always_comb begin
      sx_full = (SXW'(prod_e_ff) << FRAC_BITS) + (SXW'(1) << (ANG_SHIFT - 1));
      sx_shr  = sx_full >> ANG_SHIFT;
      sx_sat  = (sx_shr > SXW'(SRC_X_MAX)) ? SRC_X_BITS'(SRC_X_MAX)
                                           : sx_shr[SRC_X_BITS-1:0];
   end

   // drop the coordinates of pixels outside the disk
   always_ff @(posedge clock) begin
      if (adv[ST_O]) begin
         inside_ff <= ins_e_ff;
         src_x_ff  <= ins_e_ff ? sx_sat : '0;
         src_y_ff  <= ins_e_ff ? sy_e_ff : '0;
      end
   end

   assign rsp_inside_res = inside_ff;
   assign rsp_src_x      = src_x_ff;
   assign rsp_src_y      = src_y_ff;

endmodule

// File: rtl/ppcm_checker.sv
// ----------------------------------------------------------------------------
// ppcm_checker
// Port-level checks of the polar panorama coordinate map, bound to the top.
// ----------------------------------------------------------------------------
module ppcm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_inside_res,
   input logic [ppcm_pkg::SRC_X_BITS-1:0]      rsp_src_x,
   input logic [ppcm_pkg::SRC_Y_BITS-1:0]      rsp_src_y,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [ppcm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input logic [ppcm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input logic [ppcm_pkg::CSR_DATA_BITS-1:0]   csr_prdata
);
   import ppcm_pkg::*;

   logic csr_wr;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_src_x) &&
                                 $stable(rsp_src_y) && $stable(rsp_inside_res))
      else $error("stalled response changed");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_src_x == '0 && rsp_src_y == '0)
      else $error("outside pixel with nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_csr_width: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr[CSR_IDX_BIT] == REG_SRC_WIDTH |=>
         csr_paddr[CSR_IDX_BIT] != REG_SRC_WIDTH ||
         csr_prdata == CSR_DATA_BITS'($past(csr_pwdata[W_BITS-1:0])))
      else $error("src_width readback differs from last write");

   a_csr_height: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr[CSR_IDX_BIT] == REG_SRC_HEIGHT |=>
         csr_paddr[CSR_IDX_BIT] != REG_SRC_HEIGHT ||
         csr_prdata == CSR_DATA_BITS'($past(csr_pwdata[H_BITS-1:0])))
      else $error("src_height readback differs from last write");

endmodule

bind polar_panorama_coord_map_unit ppcm_checker u_ppcm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res),
   .rsp_src_x      (rsp_src_x),
   .rsp_src_y      (rsp_src_y),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);
